// ===== src/qte_pkg.sv =====
// Shared types, constants and elaboration-time helpers for the quaternion to Euler block.
package qte_pkg;

  typedef logic signed [63:0] fx_t;

  typedef struct packed {
    fx_t c00;
    fx_t c10;
    fx_t c20;
    fx_t c21;
    fx_t c22;
  } dcm_t;

  localparam fx_t QPI_FIX = 64'sh0C90_FDAA_2216_8C23;
  localparam fx_t PI_FIX = QPI_FIX <<< 2;
  localparam logic [31:0] INV_GAIN = 32'h9B74_EDA8;
  localparam logic signed [63:0] ROLL_LIM = 64'sd843314857;
  localparam logic signed [63:0] PITCH_LIM = 64'sd421657428;
  localparam int ROLL_W = 31;
  localparam int PITCH_W = 30;

  // Restoring long division, evaluated on constants only.
  function automatic logic [63:0] const_udiv(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] rem;
    q = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) at 60 fraction bits by the truncated alternating series.
  function automatic fx_t micro_angle(input int i);
    logic [63:0] acc;
    logic [63:0] term;
    int n;
    acc = '0;
    if (i == 0) begin
      return QPI_FIX;
    end
    for (int k = 0; k < 61; k++) begin
      n = 2 * k + 1;
      if (i * n <= 60) begin
        term = const_udiv(64'd1 << (60 - i * n), 64'(n));
        if (k % 2 == 1) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    return fx_t'(acc);
  endfunction

endpackage

// ===== src/qte_dcm.sv =====
// Direction-cosine terms from the quaternion: products stage, then sums stage.
module qte_dcm
  import qte_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic signed [31:0] w,
  input  logic signed [31:0] x,
  input  logic signed [31:0] y,
  input  logic signed [31:0] z,
  output logic               out_vld,
  output dcm_t               terms
);

  fx_t ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;
  logic v1_r, v2_r;
  dcm_t terms_r;

  function automatic fx_t prod(input logic signed [31:0] a, input logic signed [31:0] b);
    fx_t p;
    p = fx_t'(a) * fx_t'(b);
    return p >>> 4;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
    end
    ww_r <= prod(w, w);
    xx_r <= prod(x, x);
    yy_r <= prod(y, y);
    zz_r <= prod(z, z);
    xy_r <= prod(x, y);
    wz_r <= prod(w, z);
    xz_r <= prod(x, z);
    wy_r <= prod(w, y);
    yz_r <= prod(y, z);
    wx_r <= prod(w, x);
    terms_r.c00 <= ww_r + xx_r - yy_r - zz_r;
    terms_r.c10 <= (xy_r + wz_r) <<< 1;
    terms_r.c20 <= (xz_r - wy_r) <<< 1;
    terms_r.c21 <= (yz_r + wx_r) <<< 1;
    terms_r.c22 <= ww_r - xx_r - yy_r + zz_r;
  end

  assign out_vld = v2_r;
  assign terms = terms_r;

endmodule

// ===== src/qte_norm.sv =====
// Common power-of-two normalization of three operands: max stage, then six shift stages.
module qte_norm
  import qte_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  fx_t  a,
  input  fx_t  b,
  input  fx_t  c,
  output logic out_vld,
  output fx_t  a_out,
  output fx_t  b_out,
  output fx_t  c_out
);

  localparam int NSH = 6;

  fx_t a_r [0:NSH];
  fx_t b_r [0:NSH];
  fx_t c_r [0:NSH];
  logic [60:0] m_r [0:NSH];
  logic [NSH:0] v_r;

  logic [60:0] ma, mb, mc, m_nxt;

  always_comb begin
    ma = 61'(a[63] ? -a : a);
    mb = 61'(b[63] ? -b : b);
    mc = 61'(c[63] ? -c : c);
    m_nxt = ma;
    if (mb > m_nxt) begin
      m_nxt = mb;
    end
    if (mc > m_nxt) begin
      m_nxt = mc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
    a_r[0] <= a;
    b_r[0] <= b;
    c_r[0] <= c;
    m_r[0] <= m_nxt;
  end

  for (genvar j = 0; j < NSH; j++) begin : g_sh
    localparam int SH = 32 >> j;
    logic take;
    assign take = m_r[j] < (61'd1 << (60 - SH));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
      a_r[j+1] <= take ? (a_r[j] <<< SH) : a_r[j];
      b_r[j+1] <= take ? (b_r[j] <<< SH) : b_r[j];
      c_r[j+1] <= take ? (c_r[j] <<< SH) : c_r[j];
      m_r[j+1] <= take ? (m_r[j] << SH) : m_r[j];
    end
  end

  assign out_vld = v_r[NSH];
  assign a_out = a_r[NSH];
  assign b_out = b_r[NSH];
  assign c_out = c_r[NSH];

endmodule

// ===== src/qte_cordic.sv =====
// Pipelined vectoring CORDIC: quadrant stage, then one micro-rotation per stage.
module qte_cordic
  import qte_pkg::*;
#(
  parameter int STEPS = 24,
  parameter int SBW = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_vld,
  input  fx_t            x_in,
  input  fx_t            y_in,
  input  logic [SBW-1:0] sb_in,
  output logic           out_vld,
  output fx_t            ang,
  output fx_t            mag,
  output logic [SBW-1:0] sb_out
);

  fx_t x_r [0:STEPS];
  fx_t y_r [0:STEPS];
  fx_t z_r [0:STEPS];
  logic [SBW-1:0] sb_r [0:STEPS];
  logic [STEPS:0] zf_r;
  logic [STEPS:0] v_r;

  fx_t x_nxt, y_nxt, z_nxt;

  always_comb begin
    x_nxt = x_in;
    y_nxt = y_in;
    z_nxt = '0;
    if (x_in[63]) begin
      x_nxt = -x_in;
      y_nxt = -y_in;
      z_nxt = y_in[63] ? -PI_FIX : PI_FIX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_vld;
    end
    x_r[0] <= x_nxt;
    y_r[0] <= y_nxt;
    z_r[0] <= z_nxt;
    zf_r[0] <= (x_in == '0) && (y_in == '0);
    sb_r[0] <= sb_in;
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam fx_t ANG = micro_angle(i);
    fx_t xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else begin
        v_r[i+1] <= v_r[i];
      end
      if (!y_r[i][63]) begin
        x_r[i+1] <= x_r[i] + ys;
        y_r[i+1] <= y_r[i] - xs;
        z_r[i+1] <= z_r[i] + ANG;
      end else begin
        x_r[i+1] <= x_r[i] - ys;
        y_r[i+1] <= y_r[i] + xs;
        z_r[i+1] <= z_r[i] - ANG;
      end
      zf_r[i+1] <= zf_r[i];
      sb_r[i+1] <= sb_r[i];
    end
  end

  assign out_vld = v_r[STEPS];
  assign ang = zf_r[STEPS] ? '0 : z_r[STEPS];
  assign mag = zf_r[STEPS] ? '0 : x_r[STEPS];
  assign sb_out = sb_r[STEPS];

endmodule

// ===== src/quaternion_to_euler_angles.sv =====
// Top level: quaternion to roll, pitch and yaw (ZYX) through pipelined vectoring CORDIC.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+------------------------------
//  input   | in_quat_w/x/y/z (signed Q1.30)          | start, taken when busy is low
//  result  | out_roll/pitch/yaw_angle (Q2.28, pitch Q1.28, rad) | out_valid, one-cycle strobe
//
// One quaternion enters per cycle while busy is low; each result passes through
// the two CORDIC chains (roll, then pitch) in series.
// Reset clears every valid bit at once; busy is high only during reset.
// The result side cannot stall, so the pipeline always advances.
module quaternion_to_euler_angles
  import qte_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_quat_w,
  input  logic signed [31:0] in_quat_x,
  input  logic signed [31:0] in_quat_y,
  input  logic signed [31:0] in_quat_z,
  output logic               out_valid,
  output logic signed [30:0] out_roll_angle,
  output logic signed [29:0] out_pitch_angle,
  output logic signed [30:0] out_yaw_angle
);

  // No transaction is taken while reset holds the pipeline.
  assign busy = ~rst_n;

  logic dcm_vld;
  dcm_t terms;

  qte_dcm u_dcm (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (start & ~busy),
    .w       (in_quat_w),
    .x       (in_quat_x),
    .y       (in_quat_y),
    .z       (in_quat_z),
    .out_vld (dcm_vld),
    .terms   (terms)
  );

  // Normalize the roll/pitch triple and the yaw pair separately; a zero third
  // operand leaves the yaw pair's maximum unchanged.
  logic nrp_vld, nyw_vld;
  fx_t n20, n21, n22, n00, n10, nzero;

  qte_norm u_norm_rp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dcm_vld),
    .a       (terms.c20),
    .b       (terms.c21),
    .c       (terms.c22),
    .out_vld (nrp_vld),
    .a_out   (n20),
    .b_out   (n21),
    .c_out   (n22)
  );

  qte_norm u_norm_yw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dcm_vld),
    .a       (terms.c00),
    .b       (terms.c10),
    .c       ('0),
    .out_vld (nyw_vld),
    .a_out   (n00),
    .b_out   (n10),
    .c_out   (nzero)
  );

  // Roll CORDIC carries -c20 along for pitch; yaw runs alongside in lockstep.
  logic roll_vld, yaw_vld;
  fx_t roll_z, roll_mag, yaw_z, yaw_mag;
  logic [63:0] negc20;

  qte_cordic #(.STEPS(CORDIC_STEPS), .SBW(64)) u_cordic_roll (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (nrp_vld),
    .x_in    (n22),
    .y_in    (n21),
    .sb_in   (64'(-n20)),
    .out_vld (roll_vld),
    .ang     (roll_z),
    .mag     (roll_mag),
    .sb_out  (negc20)
  );

  qte_cordic #(.STEPS(CORDIC_STEPS), .SBW(1)) u_cordic_yaw (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (nyw_vld),
    .x_in    (n00),
    .y_in    (n10),
    .sb_in   (nzero[0]),
    .out_vld (yaw_vld),
    .ang     (yaw_z),
    .mag     (yaw_mag),
    .sb_out  ()
  );

  // Gain correction of the roll magnitude: split into two 32x32 products,
  // register them, then add the high and shifted low parts.
  logic g1_vld_r, g2_vld_r;
  logic [63:0] ph_r, pl_r;
  fx_t g1_roll_r, g1_yaw_r, g1_c20_r;
  fx_t h_r, g2_roll_r, g2_yaw_r, g2_c20_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
      g2_vld_r <= 1'b0;
    end else begin
      g1_vld_r <= roll_vld & yaw_vld;
      g2_vld_r <= g1_vld_r;
    end
    ph_r <= 64'(roll_mag[63:32]) * 64'(INV_GAIN);
    pl_r <= 64'(roll_mag[31:0]) * 64'(INV_GAIN);
    g1_roll_r <= roll_z;
    g1_yaw_r <= yaw_z ^ (yaw_mag & '0);
    g1_c20_r <= fx_t'(negc20);
    h_r <= fx_t'(ph_r + (pl_r >> 32));
    g2_roll_r <= g1_roll_r;
    g2_yaw_r <= g1_yaw_r;
    g2_c20_r <= g1_c20_r;
  end

  logic pitch_vld;
  fx_t pitch_z, pitch_mag;
  logic [127:0] ry_sb;

  qte_cordic #(.STEPS(CORDIC_STEPS), .SBW(128)) u_cordic_pitch (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (g2_vld_r),
    .x_in    (h_r),
    .y_in    (g2_c20_r),
    .sb_in   ({g2_roll_r, g2_yaw_r}),
    .out_vld (pitch_vld),
    .ang     (pitch_z),
    .mag     (pitch_mag),
    .sb_out  (ry_sb)
  );

  // Round to Q2.28 (pitch Q1.28) and clamp to the field range.
  function automatic fx_t to_q28(input fx_t z, input fx_t lim);
    fx_t r;
    r = (z + (64'sd1 <<< 31)) >>> 32;
    if (r > lim) begin
      r = lim;
    end
    if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  logic out_vld_r;
  fx_t roll_q, pitch_q, yaw_q;
  logic signed [30:0] roll_r, yaw_r;
  logic signed [29:0] pitch_r;

  always_comb begin
    roll_q = to_q28(fx_t'(ry_sb[127:64]), ROLL_LIM);
    yaw_q = to_q28(fx_t'(ry_sb[63:0]), ROLL_LIM);
    pitch_q = to_q28(pitch_z ^ (pitch_mag & '0), PITCH_LIM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= pitch_vld;
    end
    roll_r <= roll_q[ROLL_W-1:0];
    yaw_r <= yaw_q[ROLL_W-1:0];
    pitch_r <= pitch_q[PITCH_W-1:0];
  end

  assign out_valid = out_vld_r;
  assign out_roll_angle = roll_r;
  assign out_pitch_angle = pitch_r;
  assign out_yaw_angle = yaw_r;

endmodule

// ===== src/qte_checker.sv =====
// Port-level checks for the quaternion to Euler block, bound to the top level.
module qte_checker #(
  parameter int CORDIC_STEPS = 24
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic signed [31:0] in_quat_w,
  input logic signed [31:0] in_quat_x,
  input logic signed [31:0] in_quat_y,
  input logic signed [31:0] in_quat_z,
  input logic               out_valid,
  input logic signed [30:0] out_roll_angle,
  input logic signed [29:0] out_pitch_angle,
  input logic signed [30:0] out_yaw_angle
);

  localparam int LAT = 14 + 2 * CORDIC_STEPS;

  a_no_busy: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy high outside reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a transaction at the fixed latency");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_roll_angle <= 31'sd843314857 && out_roll_angle >= -31'sd843314857 &&
                   out_yaw_angle <= 31'sd843314857 && out_yaw_angle >= -31'sd843314857 &&
                   out_pitch_angle <= 30'sd421657428 && out_pitch_angle >= -30'sd421657428))
    else $error("angle beyond its range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_quat_w == 0 && in_quat_x == 0 && in_quat_y == 0 &&
                        in_quat_z == 0, LAT))
    |-> (out_roll_angle == 0 && out_pitch_angle == 0 && out_yaw_angle == 0))
    else $error("zero quaternion gave nonzero angles");

endmodule

bind quaternion_to_euler_angles qte_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_qte_checker (.*);
